/* rtl/hds_pkg.sv */
`default_nettype none
package hds_pkg;

  localparam int TEMP_W  = 26;
  localparam int COORD_W = 9;
  localparam int LAMBDA_W = 16;
  localparam int COUNT_W = 32;
  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;
  localparam logic [TEMP_W-1:0] TEMP_MAX = {TEMP_W{1'b1}};

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] REG_LAMBDA_X = 3'd0;
  localparam logic [2:0] REG_LAMBDA_Y = 3'd1;
  localparam logic [2:0] REG_SOURCE   = 3'd2;
  localparam logic [2:0] REG_AMBIENT  = 3'd3;
  localparam logic [2:0] REG_CENTER_X = 3'd4;
  localparam logic [2:0] REG_CENTER_Y = 3'd5;
  localparam logic [2:0] REG_RADIUS   = 3'd6;

  typedef struct packed {
    logic [TEMP_W-1:0] t;
    logic [TEMP_W-1:0] l;
    logic [TEMP_W-1:0] r;
    logic [TEMP_W-1:0] u;
    logic [TEMP_W-1:0] d;
  } hds_nbhd_t;

endpackage
`default_nettype wire

/* rtl/heat_diffusion_stencil_step.sv */
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata cell_x, cell_y
// m        | out | m_tvalid/m_tready  | m_tdata temperature, step_count
// apb      | in  | psel/penable       | paddr, pwdata, prdata
// init writes one cell per cycle
// a step sets disc cells to the source, copies inner neighbors to edge cells, and
// passes interior cells from the old grid's single read port to the 3-stage alu
// a read passes S_RDQ and S_RDW before S_FINISH; unused codes go to S_FINISH
// reset clears the buffer select and step counter; grid contents are kept
// a stalled result holds the sequencer before its next request
`default_nettype none
module heat_diffusion_stencil_step import hds_pkg::*; #(
  parameter int GRID_W = GRID_W_DEF,
  parameter int GRID_H = GRID_H_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // cell_x, cell_y
  input  wire  [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // temperature, step_count
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW = $clog2(CELLS);
  localparam logic [COORD_W-1:0] XMAX = COORD_W'(GRID_W - 1);
  localparam logic [COORD_W-1:0] YMAX = COORD_W'(GRID_H - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CELL, S_EDGE, S_RD, S_RD_LAST, S_ALU, S_RDQ, S_RDW, S_FINISH
  } state_t;

  state_t state;
  logic [LAMBDA_W-1:0] lambda_x, lambda_y;
  logic [TEMP_W-1:0]   source_temp, ambient_temp;
  logic [5:0]          center_x, center_y;
  logic [12:0]         radius_sq;
  logic                cur;
  logic [COUNT_W-1:0]  iterations;
  logic [COORD_W-1:0]  x, y, rx, ry, nx, ny;
  logic [2:0]          k;
  logic [TEMP_W-1:0]   res_temp;
  logic [TEMP_W-1:0]   nb [4];
  logic                in_disc, edge_cell, last_cell, alu_start, alu_done;
  logic [TEMP_W-1:0]   alu_result, rdata_a, rdata_b, rdata;
  logic                wr_en, wr_buf;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [TEMP_W-1:0]   wr_data;
  logic signed [COORD_W-1:0] dx, dy;
  logic [2*COORD_W-1:0]      dxsq, dysq;
  logic [2*COORD_W:0]        dist_sq;
  hds_nbhd_t           nbhd;

  function automatic logic [AW-1:0] lin_addr(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    logic [2*COORD_W-1:0] lin;
    lin = (2*COORD_W)'(cy) * (2*COORD_W)'(GRID_W) + (2*COORD_W)'(cx);
    return lin[AW-1:0];
  endfunction

  assign pready = 1'b1;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    case (paddr[4:2])
      REG_LAMBDA_X: prdata = {16'b0, lambda_x};
      REG_LAMBDA_Y: prdata = {16'b0, lambda_y};
      REG_SOURCE:   prdata = {6'b0, source_temp};
      REG_AMBIENT:  prdata = {6'b0, ambient_temp};
      REG_CENTER_X: prdata = {26'b0, center_x};
      REG_CENTER_Y: prdata = {26'b0, center_y};
      REG_RADIUS:   prdata = {19'b0, radius_sq};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_x <= 16'd271;
      lambda_y <= 16'd271;
      source_temp <= 26'd50659328;
      ambient_temp <= 26'd19660800;
      center_x <= 6'd20;
      center_y <= 6'd30;
      radius_sq <= 13'd100;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_LAMBDA_X: lambda_x <= pwdata[15:0];
        REG_LAMBDA_Y: lambda_y <= pwdata[15:0];
        REG_SOURCE:   source_temp <= pwdata[25:0];
        REG_AMBIENT:  ambient_temp <= pwdata[25:0];
        REG_CENTER_X: center_x <= pwdata[5:0];
        REG_CENTER_Y: center_y <= pwdata[5:0];
        REG_RADIUS:   radius_sq <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  assign dx = $signed({3'b0, center_x}) - $signed(x);
  assign dy = $signed({3'b0, center_y}) - $signed(y);
  assign dxsq = (2*COORD_W)'(dx * dx);
  assign dysq = (2*COORD_W)'(dy * dy);
  assign dist_sq = {1'b0, dxsq} + {1'b0, dysq};
  assign in_disc = dist_sq <= (2*COORD_W+1)'(radius_sq);
  assign edge_cell = (x == '0) || (x == XMAX) || (y == '0) || (y == YMAX);
  assign last_cell = (x == XMAX) && (y == YMAX);

  always_comb begin
    nx = x;
    ny = y;
    if (state == S_CELL) begin
      if (x == '0) begin
        nx = COORD_W'(1);
      end else if (x == XMAX) begin
        nx = COORD_W'(GRID_W - 2);
      end else if (y == '0) begin
        ny = COORD_W'(1);
      end else if (y == YMAX) begin
        ny = COORD_W'(GRID_H - 2);
      end
    end else if (state == S_RDQ) begin
      nx = rx;
      ny = ry;
    end else begin
      case (k)
        3'd1: nx = x - COORD_W'(1);
        3'd2: nx = x + COORD_W'(1);
        3'd3: ny = y - COORD_W'(1);
        3'd4: ny = y + COORD_W'(1);
        default: ;
      endcase
    end
  end

  assign rd_addr = lin_addr(nx, ny);
  assign wr_addr = lin_addr(x, y);
  assign rdata = cur ? rdata_b : rdata_a;

  always_comb begin
    wr_en = 1'b0;
    wr_buf = ~cur;
    wr_data = alu_result;
    unique case (state)
      S_INIT: begin
        wr_en = 1'b1;
        wr_buf = cur;
        wr_data = in_disc ? source_temp : ambient_temp;
      end
      S_CELL: begin
        wr_en = in_disc;
        wr_data = source_temp;
      end
      S_EDGE: begin
        wr_en = 1'b1;
        wr_data = rdata;
      end
      S_ALU: wr_en = alu_done;
      default: ;
    endcase
  end

  // lower neighbor comes straight from the memory as the alu starts
  assign nbhd = '{t: nb[0], l: nb[1], r: nb[2], u: nb[3], d: rdata};
  assign alu_start = (state == S_RD_LAST);

  hds_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_grid_a (
    .clk(clk), .we(wr_en && !wr_buf), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rdata_a)
  );

  hds_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_grid_b (
    .clk(clk), .we(wr_en && wr_buf), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rdata_b)
  );

  hds_cell_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .nbhd(nbhd),
    .lambda_x(lambda_x), .lambda_y(lambda_y), .done(alu_done), .result(alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur <= 1'b0;
      iterations <= '0;
      m_tvalid <= 1'b0;
      k <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          x <= '0;
          y <= '0;
          res_temp <= '0;
          rx <= {3'b0, s_tdata[5:0]};
          ry <= {3'b0, s_tdata[11:6]};
          if (s_tvalid) begin
            case (s_tuser)
              REQ_INIT: state <= S_INIT;
              REQ_STEP: state <= S_CELL;
              REQ_READ: begin
                if (({3'b0, s_tdata[5:0]} < COORD_W'(GRID_W)) &&
                    ({3'b0, s_tdata[11:6]} < COORD_W'(GRID_H))) begin
                  state <= S_RDQ;
                end else begin
                  state <= S_FINISH;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_INIT: begin
          if (last_cell) begin
            iterations <= '0;
            state <= S_FINISH;
          end else if (x == XMAX) begin
            x <= '0;
            y <= y + COORD_W'(1);
          end else begin
            x <= x + COORD_W'(1);
          end
        end
        S_CELL: begin
          k <= '0;
          if (!in_disc) begin
            state <= edge_cell ? S_EDGE : S_RD;
          end
        end
        S_RD: begin
          if (k != '0) begin
            nb[2'(k - 3'd1)] <= rdata;
          end
          k <= k + 3'd1;
          if (k == 3'd4) begin
            state <= S_RD_LAST;
          end
        end
        S_RD_LAST: state <= S_ALU;
        S_RDQ: state <= S_RDW;
        S_RDW: begin
          res_temp <= rdata;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'b0, iterations, res_temp};
            state <= S_IDLE;
          end
        end
        default: ;
      endcase
      if ((state == S_CELL && in_disc) || state == S_EDGE || (state == S_ALU && alu_done)) begin
        if (last_cell) begin
          cur <= ~cur;
          iterations <= iterations + COUNT_W'(1);
          state <= S_FINISH;
        end else begin
          state <= S_CELL;
          if (x == XMAX) begin
            x <= '0;
            y <= y + COORD_W'(1);
          end else begin
            x <= x + COORD_W'(1);
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_alu_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_ALU) else $error("alu result outside wait state");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE && state != S_FINISH)) else $error("grid write while idle");
  a_read_index: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> k <= 3'd4) else $error("neighbor index overrun");
  a_alu_start: assert property (@(posedge clk) disable iff (rst)
    alu_start |=> state == S_ALU) else $error("alu started without wait");
`endif

endmodule
`default_nettype wire

/* rtl/hds_ram.sv */
`default_nettype none
module hds_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/hds_cell_alu.sv */
`default_nettype none
module hds_cell_alu import hds_pkg::*; (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire hds_nbhd_t          nbhd,
  input  wire  [LAMBDA_W-1:0]     lambda_x,
  input  wire  [LAMBDA_W-1:0]     lambda_y,
  output logic                    done,
  output logic [TEMP_W-1:0]       result
);

  localparam int DW = TEMP_W + 2;
  localparam int PW = DW + LAMBDA_W + 1;

  logic                 v0, v1;
  logic [TEMP_W-1:0]    t0, t1;
  logic signed [DW-1:0] dxx, dyy;
  logic signed [PW-1:0] px, py;
  logic signed [31:0]   sum;

  assign sum = $signed({6'b0, t1}) + 32'(px >>> 16) + 32'(py >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      done <= v1;
    end
    t0 <= nbhd.t;
    dxx <= $signed({2'b0, nbhd.l}) + $signed({2'b0, nbhd.r}) - $signed({1'b0, nbhd.t, 1'b0});
    dyy <= $signed({2'b0, nbhd.u}) + $signed({2'b0, nbhd.d}) - $signed({1'b0, nbhd.t, 1'b0});
    t1 <= t0;
    px <= dxx * $signed({1'b0, lambda_x});
    py <= dyy * $signed({1'b0, lambda_y});
    if (sum < 0) begin
      result <= '0;
    end else if (sum > $signed({6'b0, TEMP_MAX})) begin
      result <= TEMP_MAX;
    end else begin
      result <= sum[TEMP_W-1:0];
    end
  end

endmodule
`default_nettype wire
